>>> design/hrmp_pkg.sv
// shared types and constants of the heart rate measurement parser
`timescale 1ns / 1ps
package hrmp_pkg;

  // result kinds
  localparam logic [1:0] KIND_RATE   = 2'd0;
  localparam logic [1:0] KIND_ENERGY = 2'd1;
  localparam logic [1:0] KIND_RR     = 2'd2;
  localparam logic [1:0] KIND_END    = 2'd3;

  // bit positions in the flags byte on the wire
  localparam int IN_LONG_BIT   = 0;
  localparam int IN_ENERGY_BIT = 3;
  localparam int IN_RR_BIT     = 4;

  // bit positions in the kept flag bits
  localparam int FB_LONG   = 0;
  localparam int FB_ENERGY = 1;
  localparam int FB_RR     = 2;

  // rr interval conversion: 1/1024 s units to ms
  localparam int RR_MUL_W = 10;
  localparam logic [RR_MUL_W-1:0] RR_MS_NUM = 10'd1000;
  localparam int RR_SHIFT = 10;
  localparam int FIELD_W  = 16;
  localparam int PROD_W   = FIELD_W + RR_MUL_W;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  localparam logic [QCNT_W-1:0] QFULL = QCNT_W'(QDEPTH);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [FIELD_W-1:0] field_value;
    logic               status;
    logic               packet_end;
  } out_t;

  // classified transaction waiting for the back end; word is raw for rr
  typedef struct packed {
    logic [1:0]         kind;
    logic [FIELD_W-1:0] word;
    logic               status;
    logic               packet_end;
  } qent_t;

  // queue handshake toward the producer side
  typedef struct packed {
    logic push;
    logic full;
  } qwr_ctl_t;

  // queue handshake toward the consumer side
  typedef struct packed {
    logic pop;
    logic nonempty;
  } qrd_ctl_t;

endpackage

>>> design/heart_rate_measurement_parser_top.sv
// top level of the heart rate measurement parser
`timescale 1ns / 1ps
// input channel: one byte of a heart rate measurement value per transaction,
//   flags byte first, last_byte set on the final byte of the value
// output channel: at most one result per byte: heart rate, energy expended,
//   rr interval in ms, or an end mark when the final byte completes nothing;
//   status flags a packet that ended before its required fields
// throughput: one byte per cycle, sustained, while the receiver keeps up
// result path: the completing byte is classified by the front end, written
//   to the queue, then registered in the result register that drives out_valid
// the front end parses and classifies; a four-entry queue decouples it from
//   the back end, whose single 16x10 multiply converts rr intervals
// stall: out_valid and out_data hold while out_ready is low; bytes keep
//   being accepted until the queue fills, then in_ready drops
// reset: rst_n low at a clock edge empties the queue and the result register
//   and returns the parser to expecting a flags byte
// after every final byte the parser returns to expecting a flags byte
module heart_rate_measurement_parser_top (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  hrmp_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output hrmp_pkg::out_t  out_data
);

  hrmp_pkg::qent_t     wr_entry, rd_entry;
  hrmp_pkg::qwr_ctl_t  wr_ctl;
  hrmp_pkg::qrd_ctl_t  rd_ctl;
  logic                push, pop;

  hrmp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (wr_ctl.full),
    .q_push   (push),
    .q_entry  (wr_entry)
  );

  hrmp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_entry (wr_entry),
    .wr_push  (push),
    .wr_ctl   (wr_ctl),
    .rd_pop   (pop),
    .rd_ctl   (rd_ctl),
    .rd_entry (rd_entry)
  );

  hrmp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_ctl     (rd_ctl),
    .q_entry   (rd_entry),
    .q_pop     (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> design/hrmp_front.sv
// front end: accepts bytes, tracks parse phase, classifies completed fields
`timescale 1ns / 1ps
module hrmp_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  hrmp_pkg::in_t    in_data,
  input  logic             q_full,
  output logic             q_push,
  output hrmp_pkg::qent_t  q_entry
);

  typedef enum logic [2:0] {
    PH_FLAGS  = 3'd0,
    PH_HR_LO  = 3'd1,
    PH_HR_HI  = 3'd2,
    PH_EE_LO  = 3'd3,
    PH_EE_HI  = 3'd4,
    PH_RR_LO  = 3'd5,
    PH_RR_HI  = 3'd6,
    PH_IGNORE = 3'd7
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [2:0] flags_r, flags_nxt;
  logic [7:0] hold_r, hold_nxt;
  logic       have;
  logic       accept;
  logic [1:0] kind;
  logic [hrmp_pkg::FIELD_W-1:0] word;
  logic [7:0] b;
  logic       last;

  function automatic phase_t after_rate(input logic [2:0] fl);
    phase_t p;
    if (fl[hrmp_pkg::FB_ENERGY]) begin
      p = PH_EE_LO;
    end else if (fl[hrmp_pkg::FB_RR]) begin
      p = PH_RR_LO;
    end else begin
      p = PH_IGNORE;
    end
    return p;
  endfunction

  assign b        = in_data.data_byte;
  assign last     = in_data.last_byte;
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    phase_nxt = phase_r;
    flags_nxt = flags_r;
    hold_nxt  = hold_r;
    have      = 1'b0;
    kind      = hrmp_pkg::KIND_END;
    word      = '0;
    case (phase_r)
      PH_FLAGS: begin
        flags_nxt = {b[hrmp_pkg::IN_RR_BIT], b[hrmp_pkg::IN_ENERGY_BIT],
                     b[hrmp_pkg::IN_LONG_BIT]};
        phase_nxt = PH_HR_LO;
      end
      PH_HR_LO: begin
        if (flags_r[hrmp_pkg::FB_LONG]) begin
          hold_nxt  = b;
          phase_nxt = PH_HR_HI;
        end else begin
          have      = 1'b1;
          kind      = hrmp_pkg::KIND_RATE;
          word      = {8'h00, b};
          phase_nxt = after_rate(flags_r);
        end
      end
      PH_HR_HI: begin
        have      = 1'b1;
        kind      = hrmp_pkg::KIND_RATE;
        word      = {b, hold_r};
        phase_nxt = after_rate(flags_r);
      end
      PH_EE_LO: begin
        hold_nxt  = b;
        phase_nxt = PH_EE_HI;
      end
      PH_EE_HI: begin
        have      = 1'b1;
        kind      = hrmp_pkg::KIND_ENERGY;
        word      = {b, hold_r};
        phase_nxt = flags_r[hrmp_pkg::FB_RR] ? PH_RR_LO : PH_IGNORE;
      end
      PH_RR_LO: begin
        hold_nxt  = b;
        phase_nxt = PH_RR_HI;
      end
      PH_RR_HI: begin
        have      = 1'b1;
        kind      = hrmp_pkg::KIND_RR;
        word      = {b, hold_r};
        phase_nxt = PH_RR_LO;
      end
      default: begin
        phase_nxt = PH_IGNORE;
      end
    endcase
  end

  assign q_push             = accept && (have || last);
  assign q_entry.kind       = kind;
  assign q_entry.word       = word;
  assign q_entry.packet_end = last;
  assign q_entry.status     = last && (phase_nxt == PH_HR_LO || phase_nxt == PH_HR_HI ||
                                       phase_nxt == PH_EE_LO || phase_nxt == PH_EE_HI);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FLAGS;
      flags_r <= '0;
      hold_r  <= '0;
    end else if (accept) begin
      if (last) begin
        phase_r <= PH_FLAGS;
        flags_r <= '0;
        hold_r  <= '0;
      end else begin
        phase_r <= phase_nxt;
        flags_r <= flags_nxt;
        hold_r  <= hold_nxt;
      end
    end
  end

endmodule

>>> design/hrmp_queue.sv
// short queue of classified transactions between front and back end
`timescale 1ns / 1ps
module hrmp_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  hrmp_pkg::qent_t     wr_entry,
  input  logic                wr_push,
  output hrmp_pkg::qwr_ctl_t  wr_ctl,
  input  logic                rd_pop,
  output hrmp_pkg::qrd_ctl_t  rd_ctl,
  output hrmp_pkg::qent_t     rd_entry
);

  hrmp_pkg::qent_t                 slot_r [hrmp_pkg::QDEPTH];
  logic [hrmp_pkg::QPTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [hrmp_pkg::QCNT_W-1:0]     count_r;
  logic                            push, pop;

  assign push = wr_push && (count_r != hrmp_pkg::QFULL);
  assign pop  = rd_pop && (count_r != '0);

  assign wr_ctl.push     = push;
  assign wr_ctl.full     = (count_r == hrmp_pkg::QFULL);
  assign rd_ctl.pop      = pop;
  assign rd_ctl.nonempty = (count_r != '0);
  assign rd_entry        = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    wr_push |-> (count_r != hrmp_pkg::QFULL))
    else $error("queue written while full");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= hrmp_pkg::QFULL)
    else $error("queue count beyond depth");

  a_count_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not follow a push");

  a_count_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> count_r == $past(count_r) - 1'b1)
    else $error("queue count did not follow a pop");
`endif

endmodule

>>> design/hrmp_back.sv
// back end: converts rr intervals to ms and holds the result register
`timescale 1ns / 1ps
module hrmp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  hrmp_pkg::qrd_ctl_t  q_ctl,
  input  hrmp_pkg::qent_t     q_entry,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output hrmp_pkg::out_t      out_data
);

  logic                           out_valid_r;
  hrmp_pkg::out_t                 out_data_r, out_data_nxt;
  logic [hrmp_pkg::PROD_W-1:0]    prod;

  assign q_pop = q_ctl.nonempty && (!out_valid_r || out_ready);

  assign prod = hrmp_pkg::PROD_W'(q_entry.word) * hrmp_pkg::PROD_W'(hrmp_pkg::RR_MS_NUM);

  always_comb begin
    out_data_nxt.kind       = q_entry.kind;
    out_data_nxt.status     = q_entry.status;
    out_data_nxt.packet_end = q_entry.packet_end;
    if (q_entry.kind == hrmp_pkg::KIND_RR) begin
      out_data_nxt.field_value = prod[hrmp_pkg::RR_SHIFT +: hrmp_pkg::FIELD_W];
    end else begin
      out_data_nxt.field_value = q_entry.word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> tb/heart_rate_measurement_parser_top_tb.sv
// self-checking testbench for the heart rate measurement parser top level
`timescale 1ns / 1ps
module heart_rate_measurement_parser_top_tb;

  localparam int STALL_LIMIT  = 5000;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 8;

  typedef enum logic [2:0] {
    PH_FLAGS, PH_RATE_LO, PH_RATE_HI, PH_ENERGY_LO,
    PH_ENERGY_HI, PH_RR_LO, PH_RR_HI, PH_SKIP
  } phase_t;

  typedef logic [7:0] octets_t[$];

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  hrmp_pkg::in_t  in_data;
  logic out_valid;
  logic out_ready;
  hrmp_pkg::out_t out_data;

  // parser state as the checker sees it
  phase_t     cur_phase;
  logic [2:0] flag_keep;
  logic [7:0] lo_hold;

  hrmp_pkg::out_t pending_fields[$];
  int   mismatches;
  int   bytes_sent;
  int   fields_seen;
  int   packets_sent;
  int   short_packets;
  int   long_holds;
  int   idle_cycles;
  bit   no_gaps;
  bit   rx_hold_req;
  int   rx_stall;

  heart_rate_measurement_parser_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void reset_parser_model();
    cur_phase = PH_FLAGS;
    flag_keep = '0;
    lo_hold   = '0;
  endfunction

  function automatic phase_t phase_after_rate();
    if (flag_keep[hrmp_pkg::FB_ENERGY]) return PH_ENERGY_LO;
    if (flag_keep[hrmp_pkg::FB_RR]) return PH_RR_LO;
    return PH_SKIP;
  endfunction

  // works out the result, if any, that one accepted byte causes
  function automatic void decode_byte(input hrmp_pkg::in_t b, output bit has_field,
                                      output hrmp_pkg::out_t field);
    phase_t      nxt;
    logic [15:0] word;
    logic [25:0] prod;
    nxt       = cur_phase;
    has_field = 1'b0;
    field     = '0;
    word      = {b.data_byte, lo_hold};
    case (cur_phase)
      PH_FLAGS: begin
        flag_keep[hrmp_pkg::FB_LONG]   = b.data_byte[hrmp_pkg::IN_LONG_BIT];
        flag_keep[hrmp_pkg::FB_ENERGY] = b.data_byte[hrmp_pkg::IN_ENERGY_BIT];
        flag_keep[hrmp_pkg::FB_RR]     = b.data_byte[hrmp_pkg::IN_RR_BIT];
        nxt = PH_RATE_LO;
      end
      PH_RATE_LO: begin
        if (flag_keep[hrmp_pkg::FB_LONG]) begin
          lo_hold = b.data_byte;
          nxt = PH_RATE_HI;
        end else begin
          has_field = 1'b1;
          field.kind = hrmp_pkg::KIND_RATE;
          field.field_value = {8'h00, b.data_byte};
          nxt = phase_after_rate();
        end
      end
      PH_RATE_HI: begin
        has_field = 1'b1;
        field.kind = hrmp_pkg::KIND_RATE;
        field.field_value = word;
        nxt = phase_after_rate();
      end
      PH_ENERGY_LO: begin
        lo_hold = b.data_byte;
        nxt = PH_ENERGY_HI;
      end
      PH_ENERGY_HI: begin
        has_field = 1'b1;
        field.kind = hrmp_pkg::KIND_ENERGY;
        field.field_value = word;
        nxt = flag_keep[hrmp_pkg::FB_RR] ? PH_RR_LO : PH_SKIP;
      end
      PH_RR_LO: begin
        lo_hold = b.data_byte;
        nxt = PH_RR_HI;
      end
      PH_RR_HI: begin
        has_field = 1'b1;
        field.kind = hrmp_pkg::KIND_RR;
        prod = {10'd0, word} * 26'd1000;
        field.field_value = prod[25:10];
        nxt = PH_RR_LO;
      end
      default: nxt = PH_SKIP;
    endcase
    if (b.last_byte) begin
      if (!has_field) begin
        has_field = 1'b1;
        field.kind = hrmp_pkg::KIND_END;
        field.field_value = '0;
      end
      field.status = (nxt >= PH_RATE_LO && nxt <= PH_ENERGY_HI);
      field.packet_end = 1'b1;
      reset_parser_model();
    end else begin
      cur_phase = nxt;
    end
  endfunction

  // predicts on every accepted byte and checks every accepted result
  always @(posedge clk) begin
    bit             made_one;
    hrmp_pkg::out_t made;
    hrmp_pkg::out_t want;
    if (!rst_n) begin
      reset_parser_model();
      idle_cycles <= 0;
    end else begin
      if (out_valid && out_ready) begin
        fields_seen++;
        if (pending_fields.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: kind %0d value %0d status %0b end %0b",
                     out_data.kind, out_data.field_value, out_data.status,
                     out_data.packet_end);
        end else begin
          want = pending_fields.pop_front();
          if (out_data.kind !== want.kind ||
              out_data.field_value !== want.field_value ||
              out_data.status !== want.status ||
              out_data.packet_end !== want.packet_end) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
                       want.kind, want.field_value, want.status, want.packet_end,
                       out_data.kind, out_data.field_value, out_data.status,
                       out_data.packet_end);
          end
        end
      end
      if (in_valid && in_ready) begin
        bytes_sent++;
        decode_byte(in_data, made_one, made);
        if (made_one) begin
          pending_fields.push_back(made);
          if (made.status) short_packets++;
        end
      end
      idle_cycles <= ((in_valid && in_ready) || (out_valid && out_ready)) ? 0 : idle_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= STALL_LIMIT);
    $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
    $display("heart_rate_measurement_parser_top_tb: errors");
    $finish;
  end

  // result side: random stalls, plus a long hold on request
  initial begin : receiver
    int r;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        rx_stall = LONG_HOLD;
        long_holds++;
      end else if (rx_stall == 0 && !no_gaps) begin
        r = $urandom_range(0, 99);
        if (r < 15) rx_stall = $urandom_range(1, 3);
        else if (r < 17) rx_stall = $urandom_range(20, 60);
      end
      if (rx_stall != 0) begin
        out_ready <= 1'b0;
        rx_stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_octet(input logic [7:0] d, input logic is_last);
    int r;
    int gap;
    hrmp_pkg::in_t item;
    gap = 0;
    if (!no_gaps) begin
      r = $urandom_range(0, 99);
      if (r < 55) gap = 0;
      else if (r < 90) gap = $urandom_range(1, 3);
      else if (r < 98) gap = $urandom_range(4, 10);
      else gap = $urandom_range(20, 50);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.data_byte = d;
    item.last_byte = is_last;
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_packet(input octets_t pkt);
    packets_sent++;
    foreach (pkt[i]) send_octet(pkt[i], i == pkt.size() - 1);
  endtask

  task automatic test_short_packets();
    send_packet('{8'h00});
    send_packet('{8'h01, 8'h34});
    send_packet('{8'h08, 8'h00, 8'hFF});
  endtask

  task automatic test_rate_forms();
    send_packet('{8'h00, 8'hFF});
    send_packet('{8'hE6, 8'h00, 8'hAA, 8'h55});
  endtask

  task automatic test_energy_and_rr();
    send_packet('{8'h19, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h7B});
    send_packet('{8'h10, 8'h48, 8'h00, 8'h04});
  endtask

  task automatic test_random_packets(input int n_bytes);
    octets_t    pkt;
    logic [7:0] flags;
    int         added;
    int         mode;
    int         cut;
    added = 0;
    while (added < n_bytes) begin
      pkt.delete();
      mode  = $urandom_range(0, 99);
      flags = 8'($urandom_range(0, 255));
      if (mode < 8) begin
        repeat ($urandom_range(1, 8)) pkt.push_back(8'($urandom_range(0, 255)));
      end else begin
        pkt.push_back(flags);
        pkt.push_back(8'($urandom_range(0, 255)));
        if (flags[hrmp_pkg::IN_LONG_BIT]) pkt.push_back(8'($urandom_range(0, 255)));
        if (flags[hrmp_pkg::IN_ENERGY_BIT])
          repeat (2) pkt.push_back(8'($urandom_range(0, 255)));
        if (flags[hrmp_pkg::IN_RR_BIT]) repeat (2 * $urandom_range(0, 4))
          pkt.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) == 0) pkt.push_back(8'($urandom_range(0, 255)));
        // broken packet: cut somewhere before its end
        if (mode < 20 && pkt.size() > 1) begin
          cut = $urandom_range(1, pkt.size() - 1);
          while (pkt.size() > cut) void'(pkt.pop_back());
        end
      end
      added += pkt.size();
      send_packet(pkt);
    end
  endtask

  task automatic test_streaming();
    no_gaps = 1'b1;
    test_random_packets(120);
    no_gaps = 1'b0;
  endtask

  task automatic test_backpressure();
    octets_t pkt;
    pkt.push_back(8'h10);
    pkt.push_back(8'($urandom_range(0, 255)));
    repeat (40) pkt.push_back(8'($urandom_range(0, 255)));
    no_gaps = 1'b1;
    rx_hold_req = 1'b1;
    send_packet(pkt);
    no_gaps = 1'b0;
  endtask

  initial begin
    in_valid      = 1'b0;
    in_data       = '0;
    out_ready     = 1'b0;
    rst_n         = 1'b0;
    mismatches    = 0;
    bytes_sent    = 0;
    fields_seen   = 0;
    packets_sent  = 0;
    short_packets = 0;
    long_holds    = 0;
    idle_cycles   = 0;
    no_gaps       = 1'b0;
    rx_hold_req   = 1'b0;
    rx_stall      = 0;
    reset_parser_model();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_short_packets();
    test_rate_forms();
    test_energy_and_rr();
    test_backpressure();
    test_streaming();
    test_random_packets(1250);

    in_valid <= 1'b0;
    while (pending_fields.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_fields.size() != 0) begin
      mismatches++;
      $display("%0d expected results never arrived", pending_fields.size());
    end

    $display("sent %0d bytes in %0d packets, checked %0d results (%0d short packets)",
             bytes_sent, packets_sent, fields_seen, short_packets);
    $display("receiver long holds: %0d, mismatches: %0d", long_holds, mismatches);
    if (mismatches == 0) begin
      $display("heart_rate_measurement_parser_top_tb: clean");
    end else begin
      $display("heart_rate_measurement_parser_top_tb: errors");
    end
    $finish;
  end

endmodule

>>> heart_rate_measurement_parser_top.f
design/hrmp_pkg.sv
design/hrmp_front.sv
design/hrmp_queue.sv
design/hrmp_back.sv
design/heart_rate_measurement_parser_top.sv
tb/heart_rate_measurement_parser_top_tb.sv
